// ===== hdl/mdrb_pkg.sv =====
// shared constants and types for the multiplicative digital root binner
package mdrb_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int BASE_W          = 5;
	localparam int ROOT_W          = 4;
	localparam int STATUS_W        = 2;
	localparam int MODE_W          = 2;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	localparam logic [BASE_W-1:0] BASE_RST = 5'd10;
	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

	// negative handling modes
	localparam logic [MODE_W-1:0] MODE_MAGNITUDE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DROP      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ERROR     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RST       = MODE_ERROR;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_SORTED  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;

	// register index codes (paddr[2])
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_MODE = 1'b1;

	// core result handed back to the top level
	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} core_res_t;

endpackage

// ===== hdl/mdrb_core.sv =====
// digit-serial multiplicative digital root unit: bit-serial division by the base
module mdrb_core #(
	parameter int VALUE_WIDTH = mdrb_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_WIDTH-1:0]        mag,
	input  logic [mdrb_pkg::BASE_W-1:0]   base,
	output mdrb_pkg::core_res_t           res
);

	localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_DIV  = 3'b010,
		C_DONE = 3'b100
	} cstate_t;

	cstate_t                       state_q;
	logic [VALUE_WIDTH-1:0]        dq_q;
	logic [VALUE_WIDTH-1:0]        prod_q;
	logic [mdrb_pkg::ROOT_W-1:0]   rem_q;
	logic [mdrb_pkg::ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]              cnt_q;

	logic [mdrb_pkg::BASE_W-1:0]   rem_sh;
	logic                          qbit;
	logic [mdrb_pkg::ROOT_W-1:0]   rem_nx;
	logic [VALUE_WIDTH-1:0]        quot_nx;
	logic [VALUE_WIDTH+3:0]        prod_wide;
	logic [VALUE_WIDTH-1:0]        prod_nx;
	logic                          nx_below;
	logic                          mag_below;

	// one restoring division step per cycle
	always_comb begin
		rem_sh    = {rem_q, dq_q[VALUE_WIDTH-1]};
		qbit      = (rem_sh >= base);
		rem_nx    = qbit ? mdrb_pkg::ROOT_W'(rem_sh - base) : rem_sh[mdrb_pkg::ROOT_W-1:0];
		quot_nx   = {dq_q[VALUE_WIDTH-2:0], qbit};
		prod_wide = prod_q * rem_nx;
		prod_nx   = prod_wide[VALUE_WIDTH-1:0];
		nx_below  = (prod_nx < {{(VALUE_WIDTH-mdrb_pkg::BASE_W){1'b0}}, base});
		mag_below = (mag < {{(VALUE_WIDTH-mdrb_pkg::BASE_W){1'b0}}, base});
	end

	// sequencer: digit extraction, product update, pass restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						if (mag_below) begin
							root_q  <= mag[mdrb_pkg::ROOT_W-1:0];
							state_q <= C_DONE;
						end else begin
							dq_q    <= mag;
							prod_q  <= VALUE_WIDTH'(1);
							rem_q   <= '0;
							state_q <= C_DIV;
						end
					end
				end
				C_DIV: begin
					dq_q  <= quot_nx;
					rem_q <= rem_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						cnt_q <= '0;
						rem_q <= '0;
						if (rem_nx == '0) begin
							// a zero digit forces the root to zero
							root_q  <= '0;
							state_q <= C_DONE;
						end else if (quot_nx != '0) begin
							prod_q <= prod_nx;
						end else if (nx_below) begin
							root_q  <= prod_nx[mdrb_pkg::ROOT_W-1:0];
							state_q <= C_DONE;
						end else begin
							// next pass on the digit product
							dq_q   <= prod_nx;
							prod_q <= VALUE_WIDTH'(1);
						end
					end
				end
				C_DONE: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign res.done = (state_q == C_DONE);
	assign res.root = root_q;

endmodule

// ===== hdl/multiplicative_digital_root_binner.sv =====
// top level: configuration port, handshakes and negative handling
//
//  channel  direction  handshake            word
//  in       input      in_valid / in_stall  value
//  out      output     out_valid/out_stall  root, sorted_value, status
//  cfg      apb        psel/penable/pready  digit_base, negative_mode
//
// An item runs through the bit-serial divider one base digit at a time, over all
// passes of the digit product up to the first zero digit or a single-digit product.
// Dropped and rejected words go from acceptance through the S_FIN state to the
// output register; already-small values pass through the core's C_DONE state first.
// Reset clears control state and loads digit_base 10 and negative_mode 2.
// in_stall is high while an item is in work; a stalled result holds.
module multiplicative_digital_root_binner #(
	parameter int VALUE_WIDTH = mdrb_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [63:0]                     value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mdrb_pkg::ROOT_W-1:0]     root,
	output logic [63:0]                     sorted_value,
	output logic [mdrb_pkg::STATUS_W-1:0]   status,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mdrb_pkg::ADDR_W-1:0]     paddr,
	input  logic [mdrb_pkg::DATA_W-1:0]     pwdata,
	output logic [mdrb_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_BUSY = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t                          state_q;
	logic [mdrb_pkg::BASE_W-1:0]     base_q;
	logic [mdrb_pkg::MODE_W-1:0]     mode_q;
	logic [VALUE_WIDTH-1:0]          mag_q;
	logic [mdrb_pkg::ROOT_W-1:0]     root_q;
	logic [mdrb_pkg::STATUS_W-1:0]   status_q;
	logic                            out_valid_q;
	logic [mdrb_pkg::ROOT_W-1:0]     oroot_q;
	logic [63:0]                     osv_q;
	logic [mdrb_pkg::STATUS_W-1:0]   ostat_q;

	logic [mdrb_pkg::BASE_W-1:0]     base_eff;
	logic [VALUE_WIDTH-1:0]          in_v;
	logic                            in_neg;
	logic [VALUE_WIDTH-1:0]          in_mag;
	logic                            accept;
	logic                            core_start;
	logic                            out_free;
	mdrb_pkg::core_res_t             core_res;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= mdrb_pkg::BASE_RST;
			mode_q <= mdrb_pkg::MODE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				mdrb_pkg::REG_BASE: base_q <= pwdata[mdrb_pkg::BASE_W-1:0];
				mdrb_pkg::REG_MODE: mode_q <= pwdata[mdrb_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mdrb_pkg::REG_BASE: prdata = {{(mdrb_pkg::DATA_W-mdrb_pkg::BASE_W){1'b0}}, base_q};
			mdrb_pkg::REG_MODE: prdata = {{(mdrb_pkg::DATA_W-mdrb_pkg::MODE_W){1'b0}}, mode_q};
			default:            prdata = '0;
		endcase
	end

	// clamp the base into its legal range
	always_comb begin
		if (base_q < mdrb_pkg::BASE_MIN)      base_eff = mdrb_pkg::BASE_MIN;
		else if (base_q > mdrb_pkg::BASE_MAX) base_eff = mdrb_pkg::BASE_MAX;
		else                                  base_eff = base_q;
	end

	// sign and magnitude of the incoming word
	assign in_v   = value[VALUE_WIDTH-1:0];
	assign in_neg = in_v[VALUE_WIDTH-1];
	assign in_mag = in_neg ? (~in_v + VALUE_WIDTH'(1)) : in_v;

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && !in_stall;
	assign core_start = accept && !(in_neg && (mode_q != mdrb_pkg::MODE_MAGNITUDE));
	assign out_free   = !out_valid_q || !out_stall;

	mdrb_core #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.mag    (in_mag),
		.base   (base_eff),
		.res    (core_res)
	);

	// item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (core_start) begin
							mag_q    <= in_mag;
							status_q <= mdrb_pkg::STATUS_SORTED;
							state_q  <= S_BUSY;
						end else begin
							mag_q    <= '0;
							root_q   <= '0;
							status_q <= (mode_q == mdrb_pkg::MODE_DROP) ?
								mdrb_pkg::STATUS_DROPPED : mdrb_pkg::STATUS_ERROR;
							state_q  <= S_FIN;
						end
					end
				end
				S_BUSY: begin
					if (core_res.done) begin
						root_q  <= core_res.root;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
			oroot_q     <= root_q;
			osv_q       <= 64'(mag_q);
			ostat_q     <= status_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign root         = oroot_q;
	assign sorted_value = osv_q;
	assign status       = ostat_q;

endmodule
